@@ design/rmcu_pkg.sv @@
// ----------------------------------------------------------------------------
// rmcu_pkg
// Shared types and constants for the running mean / covariance block.
// ----------------------------------------------------------------------------
package rmcu_pkg;

  // item field widths
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 3;
  localparam int NP_W    = 4;
  localparam int MEAN_W  = 32;
  localparam int COV_W   = 64;
  localparam int CNT_W   = 32;

  localparam int MAX_PARAMS_DEF = 8;
  localparam logic [NP_W-1:0] NP_RESET = 4'd8;

  // shared divider geometry
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

endpackage

@@ design/rmcu_in_if.sv @@
// ----------------------------------------------------------------------------
// rmcu_in_if
// Input item channel: one sample component, clear or read request.
// ----------------------------------------------------------------------------
interface rmcu_in_if;
  logic                          valid;
  logic                          ready;
  logic [rmcu_pkg::KIND_W-1:0]   kind;
  logic signed [rmcu_pkg::VAL_W-1:0] value;
  logic [rmcu_pkg::IDX_W-1:0]    row;
  logic [rmcu_pkg::IDX_W-1:0]    col;

  modport source (output valid, kind, value, row, col, input ready);
  modport sink   (input valid, kind, value, row, col, output ready);
endinterface

@@ design/rmcu_out_if.sv @@
// ----------------------------------------------------------------------------
// rmcu_out_if
// Result item channel: selected mean, covariance entry and status.
// ----------------------------------------------------------------------------
interface rmcu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmcu_pkg::MEAN_W-1:0] mean_value;
  logic signed [rmcu_pkg::COV_W-1:0]  cov_value;
  logic [rmcu_pkg::CNT_W-1:0]         sample_count;
  logic                               cov_valid;
  logic                               saturated;

  modport source (output valid, mean_value, cov_value, sample_count, cov_valid,
                  saturated, input ready);
  modport sink   (input valid, mean_value, cov_value, sample_count, cov_valid,
                  saturated, output ready);
endinterface

@@ design/rmcu_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rmcu_cfg_if
// Configuration write channel carrying num_params.
// ----------------------------------------------------------------------------
interface rmcu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rmcu_pkg::NP_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/running_mean_covariance_update.sv @@
// ----------------------------------------------------------------------------
// running_mean_covariance_update
// Welford running mean and unbiased covariance over sample vectors.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A read, a clear or a component that does not
// end a vector passes through S_RD and S_OUT, which waits until the result
// register is free, before the next item is accepted. The component that ends
// a vector of p components runs the update on one shared 64-by-33 bit divider
// that yields one quotient bit a cycle: p mean divisions, then for each of the
// p*p covariance entries two divisions and one 32x32 multiply; on the first
// sample the covariance is only zeroed. Clear takes effect at once through
// per-entry valid bits.
module running_mean_covariance_update #(
  parameter int MAX_PARAMS = rmcu_pkg::MAX_PARAMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmcu_in_if.sink   in_if,
  rmcu_out_if.source out_if,
  rmcu_cfg_if.sink  cfg_if
);
  import rmcu_pkg::*;

  localparam int IW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int PW    = $clog2(MAX_PARAMS + 1);
  localparam int DEPTH = MAX_PARAMS * MAX_PARAMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] MAXU = 32'(MAX_PARAMS);

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_MEAN_DIV  = 13'h0002,
    S_MEAN_WAIT = 13'h0004,
    S_COV_ROW   = 13'h0008,
    S_COV_RD    = 13'h0010,
    S_COV_DIV1  = 13'h0020,
    S_COV_W1    = 13'h0040,
    S_COV_DIV2  = 13'h0080,
    S_COV_W2    = 13'h0100,
    S_FIN       = 13'h0200,
    S_RD        = 13'h0400,
    S_OUT       = 13'h0800,
    S_SPARE     = 13'h1000
  } state_t;

  state_t             state_r;
  logic [NP_W-1:0]    np_r;
  logic [CNT_W-1:0]   count_r;
  logic [IW-1:0]      pos_r, j_r, k_r;
  logic               sat_r;
  logic signed [MEAN_W-1:0] mean_r [MAX_PARAMS];

  logic signed [VAL_W-1:0]  buf_r [MAX_PARAMS];
  logic signed [32:0]       d_r   [MAX_PARAMS];
  logic signed [32:0]       dj_r, dk_r;
  logic [COV_W-1:0]         c_r, a_r, prod_r;
  logic [KIND_W-1:0]        kind_r;
  logic [IDX_W-1:0]         row_r, col_r;

  logic                     out_valid_r;
  logic [MEAN_W-1:0]        out_mean_r;
  logic [COV_W-1:0]         out_cov_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_cv_r, out_sat_r;

  logic               in_acc;
  logic [PW-1:0]      p_act;
  logic               last_pos, j_last, k_last, w_zero, rd_inr;
  logic [DIV_DW-1:0]  n_cnt;
  logic [IW-1:0]      d_idx, mean_idx, row_idx;
  logic signed [32:0] d_cur, d_rd;
  logic [32:0]        d_mag, dj_mag, dk_mag;
  logic [MEAN_W-1:0]  mean_rd;
  logic [33:0]        mean_sum;
  logic [AW-1:0]      jk_addr, out_addr;
  logic [COV_W-1:0]   c_mag, a_nxt, cov_wdata;
  logic [65:0]        sum66;
  logic               sum_hi, sum_lo, d_neg;
  state_t             adv_state;

  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_num, div_quo;
  logic [DIV_DW-1:0]  div_den;

  logic               mem_clr, mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [COV_W-1:0]   mem_wdata, mem_rdata;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;

  // active vector size and loop bounds
  always_comb begin
    if (np_r == '0)                 p_act = PW'(1);
    else if (32'(np_r) > MAXU)      p_act = PW'(MAXU);
    else                            p_act = PW'(np_r);
    last_pos = (32'(pos_r) + 32'd1 >= 32'(p_act));
    j_last   = (32'(j_r) + 32'd1 >= 32'(p_act));
    k_last   = (32'(k_r) + 32'd1 >= 32'(p_act));
    w_zero   = (count_r == '0);
    n_cnt    = {1'b0, count_r} + DIV_DW'(1);
    adv_state = k_last ? (j_last ? S_FIN : S_COV_ROW) : S_COV_RD;
  end

  // store read ports and arithmetic
  always_comb begin
    row_idx  = IW'(row_r);
    rd_inr   = (32'(row_r) < MAXU) && (32'(col_r) < MAXU);
    d_idx    = (state_r == S_COV_RD) ? k_r : j_r;
    mean_idx = (state_r == S_OUT) ? row_idx : j_r;
    d_rd     = d_r[d_idx];
    mean_rd  = mean_r[mean_idx];
    d_cur    = {buf_r[j_r][VAL_W-1], buf_r[j_r]} - {mean_rd[MEAN_W-1], mean_rd};
    d_mag    = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
    dj_mag   = dj_r[32] ? 33'(-dj_r) : 33'(dj_r);
    dk_mag   = dk_r[32] ? 33'(-dk_r) : 33'(dk_r);
    d_neg    = dj_r[32] ^ dk_r[32];
    mean_sum = {{2{mean_rd[MEAN_W-1]}}, mean_rd}
             + (d_rd[32] ? -{1'b0, div_quo[32:0]} : {1'b0, div_quo[32:0]});
    jk_addr  = AW'(32'(j_r) * MAXU + 32'(k_r));
    out_addr = rd_inr ? AW'(32'(row_r) * MAXU + 32'(col_r)) : '0;
    c_mag    = mem_rdata[COV_W-1] ? -mem_rdata : mem_rdata;
    a_nxt    = c_r[COV_W-1] ? (c_r + div_quo) : (c_r - div_quo);
    sum66    = d_neg ? ({{2{a_r[COV_W-1]}}, a_r} - {2'b0, div_quo})
                     : ({{2{a_r[COV_W-1]}}, a_r} + {2'b0, div_quo});
    sum_hi   = !sum66[65] && (sum66[64] || sum66[63]);
    sum_lo   = sum66[65] && !(sum66[64] && sum66[63]);
    if (sum_hi)      cov_wdata = {1'b0, {(COV_W-1){1'b1}}};
    else if (sum_lo) cov_wdata = {1'b1, {(COV_W-1){1'b0}}};
    else             cov_wdata = sum66[COV_W-1:0];
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_MEAN_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(d_mag);
        div_den   = n_cnt;
      end
      S_COV_DIV1: begin
        div_start = 1'b1;
        div_num   = c_mag;
        div_den   = {1'b0, count_r};
      end
      S_COV_DIV2: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = n_cnt;
      end
      default: ;
    endcase
  end

  // covariance store access
  always_comb begin
    mem_clr   = in_acc && (in_if.kind == KIND_CLEAR);
    mem_we    = 1'b0;
    mem_waddr = jk_addr;
    mem_wdata = '0;
    mem_raddr = (state_r == S_COV_RD) ? jk_addr : out_addr;
    if (state_r == S_COV_RD && w_zero) mem_we = 1'b1;
    if (state_r == S_COV_W2 && div_done) begin
      mem_we    = 1'b1;
      mem_wdata = cov_wdata;
    end
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      np_r        <= NP_RESET;
      count_r     <= '0;
      pos_r       <= '0;
      j_r         <= '0;
      k_r         <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) mean_r[i] <= '0;
    end else begin
      if (cfg_if.valid) np_r <= cfg_if.data;
      if (out_valid_r && out_if.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_if.kind)
              KIND_ADD: begin
                if (last_pos) begin
                  pos_r   <= '0;
                  j_r     <= '0;
                  state_r <= S_MEAN_DIV;
                end else begin
                  pos_r   <= pos_r + 1'b1;
                  state_r <= S_RD;
                end
              end
              KIND_CLEAR: begin
                count_r <= '0;
                pos_r   <= '0;
                sat_r   <= 1'b0;
                state_r <= S_RD;
                for (int i = 0; i < MAX_PARAMS; i++) mean_r[i] <= '0;
              end
              default: state_r <= S_RD;
            endcase
          end
        end
        S_MEAN_DIV:  state_r <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_r[j_r] <= mean_sum[MEAN_W-1:0];
            if (j_last) begin
              j_r     <= '0;
              k_r     <= '0;
              state_r <= S_COV_ROW;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_MEAN_DIV;
            end
          end
        end
        S_COV_ROW: state_r <= S_COV_RD;
        S_COV_RD: begin
          if (w_zero) begin
            state_r <= adv_state;
            if (k_last) begin
              k_r <= '0;
              if (!j_last) j_r <= j_r + 1'b1;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else begin
            state_r <= S_COV_DIV1;
          end
        end
        S_COV_DIV1: state_r <= S_COV_W1;
        S_COV_W1:   if (div_done) state_r <= S_COV_DIV2;
        S_COV_DIV2: state_r <= S_COV_W2;
        S_COV_W2: begin
          if (div_done) begin
            if (sum_hi || sum_lo) sat_r <= 1'b1;
            state_r <= adv_state;
            if (k_last) begin
              k_r <= '0;
              if (!j_last) j_r <= j_r + 1'b1;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_FIN: begin
          if (count_r == {CNT_W{1'b1}}) sat_r <= 1'b1;
          else count_r <= count_r + 1'b1;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_if.kind;
      row_r  <= in_if.row;
      col_r  <= in_if.col;
      if (in_if.kind == KIND_ADD) buf_r[pos_r] <= in_if.value;
    end
    if (state_r == S_MEAN_DIV) d_r[j_r] <= d_cur;
    if (state_r == S_COV_ROW)  dj_r <= d_rd;
    if (state_r == S_COV_RD)   dk_r <= d_rd;
    if (state_r == S_COV_DIV1) c_r <= mem_rdata;
    if (state_r == S_COV_W1 && div_done) begin
      a_r    <= a_nxt;
      prod_r <= dj_mag[31:0] * dk_mag[31:0];
    end
    if (state_r == S_OUT && (!out_valid_r || out_if.ready)) begin
      out_mean_r <= rd_inr ? mean_rd : '0;
      out_cov_r  <= rd_inr ? mem_rdata : '0;
      out_cnt_r  <= count_r;
      out_cv_r   <= (count_r >= CNT_W'(2)) && (kind_r != KIND_CLEAR || 1'b1);
      out_sat_r  <= sat_r;
    end
  end

  rmcu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rmcu_cov_mem #(.DEPTH(DEPTH), .AW(AW)) u_cov_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.mean_value   = out_mean_r;
  assign out_if.cov_value    = out_cov_r;
  assign out_if.sample_count = out_cnt_r;
  assign out_if.cov_valid    = out_cv_r;
  assign out_if.saturated    = out_sat_r;
endmodule

@@ design/rmcu_div.sv @@
// ----------------------------------------------------------------------------
// rmcu_div
// Shared restoring divider, one quotient bit per cycle, round to nearest
// with ties away from zero on the unsigned magnitudes.
// ----------------------------------------------------------------------------
module rmcu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rmcu_pkg::DIV_NW-1:0] num,
  input  logic [rmcu_pkg::DIV_DW-1:0] den,
  output logic                        done,
  output logic [rmcu_pkg::DIV_NW-1:0] quo
);
  import rmcu_pkg::*;

  logic              run_r, rnd_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW:0]   rem_r;
  logic [DIV_NW-1:0] q_r, quo_r;
  logic [DIV_DW-1:0] den_r;

  logic [DIV_DW:0]   rem_sh, rem_dn;
  logic              ge, rnd_up;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r[DIV_DW-1:0], q_r[DIV_NW-1]};
    ge     = (rem_sh >= {1'b0, den_r});
    rem_dn = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
    rnd_up = ({rem_r[DIV_DW-1:0], 1'b0} >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && !run_r && rnd_r;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          run_r <= 1'b0;
          rnd_r <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_dn;
      q_r   <= {q_r[DIV_NW-2:0], ge};
    end else if (rnd_r) begin
      quo_r <= q_r + DIV_NW'(rnd_up);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

@@ design/rmcu_cov_mem.sv @@
// ----------------------------------------------------------------------------
// rmcu_cov_mem
// Covariance store: one write and one registered read per cycle, with a
// valid bit per entry so that clear takes effect at once.
// ----------------------------------------------------------------------------
module rmcu_cov_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rmcu_pkg::COV_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [rmcu_pkg::COV_W-1:0]  rdata
);
  import rmcu_pkg::*;

  logic [COV_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [COV_W-1:0] rd_r;
  logic             rvld_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (we) vld_r[waddr] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign rdata = rvld_r ? rd_r : '0;
endmodule
